### sv/u8cq_pkg.sv
// ----------------------------------------------------------------------------
// u8cq_pkg
// Shared types and constants of the UTF-8 code point queue: operation codes,
// lead byte patterns and the beat passed from the decoder to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package u8cq_pkg;

  // code point width
  localparam int unsigned CP_W = 21;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_CONSUME = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // lead byte patterns and payload masks
  localparam logic [7:0] LEAD1_MASK = 8'h80;
  localparam logic [7:0] LEAD1_PAT  = 8'h00;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD2_DATA = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD3_DATA = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] LEAD4_DATA = 8'h07;
  localparam logic [7:0] CONT_DATA  = 8'h3F;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // replacement character for a bad lead byte
  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // decoder to queue: finished code point and its fate
  typedef struct packed {
    logic            wr_en;
    logic [CP_W-1:0] wr_data;
    logic            dropped;
  } cp_wr_t;

endpackage

`default_nettype wire

### sv/u8cq_decode.sv
// ----------------------------------------------------------------------------
// u8cq_decode
// Byte-serial UTF-8 decoder. Gathers a sequence, decides whether a finished
// code point is queued or dropped, and tracks the per-string drop mode.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cq_decode (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic                   end_i,
  input  wire logic                   full_i,
  output u8cq_pkg::cp_wr_t            wr_o
);

  logic [u8cq_pkg::CP_W-1:0] pv_q, pv_d;
  logic [1:0]                bl_q, bl_d;
  logic                      drop_q, drop_d;
  logic                      fin;
  logic [u8cq_pkg::CP_W-1:0] fin_cp;
  logic                      end_s;
  logic [5:0]                cont;

  assign cont = byte_i[5:0] & u8cq_pkg::CONT_DATA[5:0];

  // sequence decode and drop decision
  always_comb begin
    pv_d         = pv_q;
    bl_d         = bl_q;
    drop_d       = drop_q;
    fin          = 1'b0;
    fin_cp       = '0;
    end_s        = end_i;
    wr_o.wr_en   = 1'b0;
    wr_o.dropped = 1'b0;

    if (bl_q != 2'd0) begin
      pv_d = {pv_q[u8cq_pkg::CP_W-7:0], cont};
      bl_d = bl_q - 2'd1;
      if (bl_q == 2'd1) begin
        fin    = 1'b1;
        fin_cp = pv_d;
        pv_d   = '0;
      end
    end else if (byte_i == u8cq_pkg::NUL_BYTE) begin
      end_s = 1'b1;
    end else if ((byte_i & u8cq_pkg::LEAD1_MASK) == u8cq_pkg::LEAD1_PAT) begin
      fin    = 1'b1;
      fin_cp = {13'd0, byte_i};
    end else if ((byte_i & u8cq_pkg::LEAD2_MASK) == u8cq_pkg::LEAD2_PAT) begin
      pv_d = {13'd0, byte_i & u8cq_pkg::LEAD2_DATA};
      bl_d = 2'd1;
    end else if ((byte_i & u8cq_pkg::LEAD3_MASK) == u8cq_pkg::LEAD3_PAT) begin
      pv_d = {13'd0, byte_i & u8cq_pkg::LEAD3_DATA};
      bl_d = 2'd2;
    end else if ((byte_i & u8cq_pkg::LEAD4_MASK) == u8cq_pkg::LEAD4_PAT) begin
      pv_d = {13'd0, byte_i & u8cq_pkg::LEAD4_DATA};
      bl_d = 2'd3;
    end else begin
      fin    = 1'b1;
      fin_cp = u8cq_pkg::REPL_CP;
    end

    // a decoded zero is neither queued nor counted as dropped
    if (fin && (fin_cp != '0)) begin
      if (drop_q) begin
        wr_o.dropped = en_i;
      end else if (full_i) begin
        drop_d       = 1'b1;
        wr_o.dropped = en_i;
      end else begin
        wr_o.wr_en = en_i;
      end
    end

    // string end throws away a partial sequence and leaves drop mode
    if (end_s) begin
      pv_d   = '0;
      bl_d   = 2'd0;
      drop_d = 1'b0;
    end

    wr_o.wr_data = fin_cp;
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      bl_q   <= 2'd0;
      drop_q <= 1'b0;
    end else if (en_i) begin
      pv_q   <= pv_d;
      bl_q   <= bl_d;
      drop_q <= drop_d;
    end
  end

endmodule

`default_nettype wire

### sv/u8cq_ram.sv
// ----------------------------------------------------------------------------
// u8cq_ram
// Code point store: one write port, one read port with registered data and
// a write-to-read bypass so the read data always shows the new head.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                            clk_i,
  input  wire logic                            rd_en_i,
  input  wire logic [AW-1:0]                   rd_addr_i,
  input  wire logic                            wr_en_i,
  input  wire logic [AW-1:0]                   wr_addr_i,
  input  wire logic [u8cq_pkg::CP_W-1:0]       wr_data_i,
  output logic      [u8cq_pkg::CP_W-1:0]       rd_data_o
);

  logic [u8cq_pkg::CP_W-1:0] mem [DEPTH];
  logic [u8cq_pkg::CP_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, bypassing a write to the same slot
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### sv/utf8_codepoint_queue.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_queue
// UTF-8 byte decoder feeding a ring queue of code points, with pop and clear.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i / in_stall_o carry one beat of op_i, data_byte_i
//   and string_end_i. Op push feeds one UTF-8 byte to the decoder, consume
//   pops the head code point, clear empties the queue.
//   Output channel: out_valid_o / out_stall_i carry exactly one result beat
//   for every input beat: the popped code point, the head after the step,
//   not-empty flag, fill level and the dropped flag.
//   Timing: an input beat lands in the input register; its result is taken
//   into the result register when the stage advances. Throughput is one
//   beat per cycle while out_stall_i stays low; the decode and queue update
//   sit in one stage between the input and result registers, with the queue
//   store read through one registered port at the next head slot.
//   Stall: while the result is held by out_stall_i the input register holds
//   too and in_stall_o rises once it is occupied; nothing is lost.
//   Reset: the queue is empty, no sequence is in progress, drop mode is off
//   and both channels are idle. The store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                op_i,
  input  wire logic [7:0]                data_byte_i,
  input  wire logic                      string_end_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [20:0]                    popped_codepoint_o,
  output logic [20:0]                    head_codepoint_o,
  output logic                           not_empty_o,
  output logic [6:0]                     fill_level_o,
  output logic                           dropped_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // input register
  logic                  in_valid_q;
  u8cq_pkg::op_e         op_q;
  logic [7:0]            byte_q;
  logic                  end_q;

  // queue state
  logic [IW-1:0]         rd_q, rd_d;
  logic [IW-1:0]         wr_q, wr_d;
  logic [CW-1:0]         cnt_q, cnt_d;

  // result register
  logic                  out_valid_q;
  logic [u8cq_pkg::CP_W-1:0] popped_q, popped_d;
  logic                  dropped_q;

  logic                  advance;
  logic                  full;
  u8cq_pkg::cp_wr_t      cp_wr;
  logic [u8cq_pkg::CP_W-1:0] head_data;
  logic [CW+6:0]         fill_ext;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    logic [IW-1:0] nxt;
    nxt = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

  // handshake: the stage moves when the result slot is free or being taken
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign full       = (cnt_q == CW'(QUEUE_DEPTH));

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q   <= u8cq_pkg::op_e'(op_i);
      byte_q <= data_byte_i;
      end_q  <= string_end_i;
    end
  end

  // byte decoder
  u8cq_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance && (op_q == u8cq_pkg::OP_PUSH)),
    .byte_i (byte_q),
    .end_i  (end_q),
    .full_i (full),
    .wr_o   (cp_wr)
  );

  // queue pointer and count update
  always_comb begin
    rd_d     = rd_q;
    wr_d     = wr_q;
    cnt_d    = cnt_q;
    popped_d = '0;
    case (op_q)
      u8cq_pkg::OP_PUSH: begin
        if (cp_wr.wr_en) begin
          wr_d  = idx_inc(wr_q);
          cnt_d = cnt_q + 1'b1;
        end
      end
      u8cq_pkg::OP_CONSUME: begin
        if (cnt_q != '0) begin
          popped_d = head_data;
          rd_d     = idx_inc(rd_q);
          cnt_d    = cnt_q - 1'b1;
        end
      end
      u8cq_pkg::OP_CLEAR: begin
        rd_d  = '0;
        wr_d  = '0;
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else if (advance) begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // code point store, read data follows the head after each step
  u8cq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (advance),
    .rd_addr_i (rd_d),
    .wr_en_i   (cp_wr.wr_en),
    .wr_addr_i (wr_q),
    .wr_data_i (cp_wr.wr_data),
    .rd_data_o (head_data)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      popped_q  <= popped_d;
      dropped_q <= cp_wr.dropped;
    end
  end

  // outputs: count and head are the live state, held while the result waits
  assign fill_ext           = {7'd0, cnt_q};
  assign out_valid_o        = out_valid_q;
  assign popped_codepoint_o = popped_q;
  assign not_empty_o        = (cnt_q != '0);
  assign head_codepoint_o   = not_empty_o ? head_data : '0;
  assign fill_level_o       = fill_ext[6:0];
  assign dropped_o          = dropped_q;

endmodule

`default_nettype wire

### sv/u8cq_checker.sv
// ----------------------------------------------------------------------------
// u8cq_sva
// Port-level checks of the UTF-8 code point queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cq_sva #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [20:0] popped_codepoint_o,
  input wire logic [20:0] head_codepoint_o,
  input wire logic        not_empty_o,
  input wire logic [6:0]  fill_level_o,
  input wire logic        dropped_o
);

  localparam bit FILL_EXACT = (QUEUE_DEPTH < 128);

  // on a valid result the fill level never goes past the queue depth (depths below 128)
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!FILL_EXACT || (32'(fill_level_o) <= QUEUE_DEPTH)))
    else $error("fill level beyond queue depth");

  // not-empty flag agrees with the fill level
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!FILL_EXACT || (not_empty_o == (fill_level_o != 7'd0))))
    else $error("not-empty flag disagrees with fill level");

  // an empty queue shows a zero head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !not_empty_o) |-> (head_codepoint_o == 21'd0))
    else $error("head code point on an empty queue");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(popped_codepoint_o)
      && $stable(head_codepoint_o) && $stable(fill_level_o) && $stable(dropped_o)))
    else $error("stalled result beat changed");

endmodule

bind utf8_codepoint_queue u8cq_sva #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .popped_codepoint_o (popped_codepoint_o),
  .head_codepoint_o   (head_codepoint_o),
  .not_empty_o        (not_empty_o),
  .fill_level_o       (fill_level_o),
  .dropped_o          (dropped_o)
);

`default_nettype wire

### sim/u8cq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u8cq_checker
// Watches both channels of the UTF-8 code point queue. Every input beat that
// is taken updates a private copy of the decoder and ring queue, and the
// status that the beat should produce is stored. Each result beat is then
// compared field by field with the oldest stored status.
// ----------------------------------------------------------------------------
module u8cq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        string_end_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [20:0] popped_codepoint_i,
  input  logic [20:0] head_codepoint_i,
  input  logic        not_empty_i,
  input  logic [6:0]  fill_level_i,
  input  logic        dropped_i,
  output int          faults_o,
  output int          pending_o,
  output int          checked_o,
  output int          discarded_o,
  output int          peak_fill_o
);

  // status carried by one result beat
  typedef struct packed {
    logic [20:0] popped;
    logic [20:0] head;
    logic        not_empty;
    logic [6:0]  fill;
    logic        dropped;
  } status_t;

  // predicted results still to come out of the block
  status_t awaited_status [$];

  int faults;
  int pending;
  int checked;
  int discarded;
  int peak_fill;

  // private copy of the decoder and ring queue
  logic [20:0] cp_ring [DEPTH];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  int unsigned cp_count;
  logic [20:0] acc_cp;
  logic [1:0]  cont_left;
  logic        discard_on;

  assign faults_o    = faults;
  assign pending_o   = pending;
  assign checked_o   = checked;
  assign discarded_o = discarded;
  assign peak_fill_o = peak_fill;

  // one line per mismatch
  task automatic report_fault(input string what, input logic [20:0] got,
                              input logic [20:0] want);
    $display("%0t: %s mismatch, got %06h want %06h", $realtime, what, got, want);
    faults++;
  endtask

  // store a finished nonzero code point, or lose it when the ring is full or drop mode is on
  task automatic enqueue_cp(input logic [20:0] cp, output logic lost);
    lost = 1'b0;
    if (cp != '0) begin
      if (discard_on) begin
        lost = 1'b1;
      end else if (cp_count >= DEPTH) begin
        discard_on = 1'b1;
        lost       = 1'b1;
      end else begin
        cp_ring[tail_ptr] = cp;
        tail_ptr          = (tail_ptr + 1) % DEPTH;
        cp_count++;
      end
    end
  endtask

  // apply one input beat and work out the status it yields
  task automatic decode_step(input u8cq_pkg::op_e op, input logic [7:0] b,
                             input logic eos_in, output status_t res);
    logic        eos;
    logic        lost;
    logic [20:0] popped;
    eos    = eos_in;
    lost   = 1'b0;
    popped = '0;
    case (op)
      u8cq_pkg::OP_PUSH: begin
        if (cont_left != 2'd0) begin
          // continuation: six more bits, top bits not checked
          acc_cp    = {acc_cp[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            enqueue_cp(acc_cp, lost);
            acc_cp = '0;
          end
        end else if (b == u8cq_pkg::NUL_BYTE) begin
          eos = 1'b1;
        end else if ((b & u8cq_pkg::LEAD1_MASK) == u8cq_pkg::LEAD1_PAT) begin
          enqueue_cp({13'd0, b}, lost);
        end else if ((b & u8cq_pkg::LEAD2_MASK) == u8cq_pkg::LEAD2_PAT) begin
          acc_cp    = {13'd0, b & u8cq_pkg::LEAD2_DATA};
          cont_left = 2'd1;
        end else if ((b & u8cq_pkg::LEAD3_MASK) == u8cq_pkg::LEAD3_PAT) begin
          acc_cp    = {13'd0, b & u8cq_pkg::LEAD3_DATA};
          cont_left = 2'd2;
        end else if ((b & u8cq_pkg::LEAD4_MASK) == u8cq_pkg::LEAD4_PAT) begin
          acc_cp    = {13'd0, b & u8cq_pkg::LEAD4_DATA};
          cont_left = 2'd3;
        end else begin
          enqueue_cp(u8cq_pkg::REPL_CP, lost);
        end
        // end of string drops any partial sequence and leaves drop mode
        if (eos) begin
          acc_cp     = '0;
          cont_left  = 2'd0;
          discard_on = 1'b0;
        end
      end
      u8cq_pkg::OP_CONSUME: begin
        if (cp_count != 0) begin
          popped   = cp_ring[head_ptr];
          head_ptr = (head_ptr + 1) % DEPTH;
          cp_count--;
        end
      end
      u8cq_pkg::OP_CLEAR: begin
        head_ptr = 0;
        tail_ptr = 0;
        cp_count = 0;
      end
      default: ;
    endcase
    res.popped    = popped;
    res.head      = (cp_count != 0) ? cp_ring[head_ptr] : '0;
    res.not_empty = (cp_count != 0);
    res.fill      = 7'(cp_count);
    res.dropped   = lost;
  endtask

  // results are checked before the same edge's input beat is predicted
  always @(posedge clk_i or negedge rst_ni) begin : watch
    status_t got;
    status_t want;
    if (!rst_ni) begin
      head_ptr   = 0;
      tail_ptr   = 0;
      cp_count   = 0;
      acc_cp     = '0;
      cont_left  = 2'd0;
      discard_on = 1'b0;
      awaited_status.delete();
      pending    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{popped_codepoint_i, head_codepoint_i, not_empty_i, fill_level_i, dropped_i};
        if (pending == 0) begin
          report_fault("result with nothing awaited", got.popped, '0);
        end else begin
          want = awaited_status.pop_front();
          pending--;
          checked++;
          if (got.popped !== want.popped)
            report_fault("popped code point", got.popped, want.popped);
          if (got.head !== want.head)
            report_fault("head code point", got.head, want.head);
          if (got.not_empty !== want.not_empty)
            report_fault("not-empty flag", got.not_empty, want.not_empty);
          if (got.fill !== want.fill)
            report_fault("fill level", got.fill, want.fill);
          if (got.dropped !== want.dropped)
            report_fault("dropped flag", got.dropped, want.dropped);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_step(u8cq_pkg::op_e'(op_i), data_byte_i, string_end_i, want);
        awaited_status.push_back(want);
        pending++;
        if (want.dropped)
          discarded++;
        if (cp_count > peak_fill)
          peak_fill = cp_count;
      end
    end
  end

endmodule

### sim/tb_utf8_codepoint_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_queue
// Drives the code point queue with a directed run through lead byte forms,
// bad leads, zero bytes and queue ops, then with random strings, truncated
// sequences, noise, consume runs and overflow bursts, under random idling on
// both channels. Checking is left to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_queue;

  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int DEPTH        = 64;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i         = u8cq_pkg::OP_NONE;
  logic [7:0]  data_byte_i  = 8'h00;
  logic        string_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [20:0] popped_codepoint_o;
  logic [20:0] head_codepoint_o;
  logic        not_empty_o;
  logic [6:0]  fill_level_o;
  logic        dropped_o;

  int faults;
  int pending;
  int checked;
  int discarded;
  int peak_fill;
  int beats_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  utf8_codepoint_queue #(
    .QUEUE_DEPTH (DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .data_byte_i        (data_byte_i),
    .string_end_i       (string_end_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .popped_codepoint_o (popped_codepoint_o),
    .head_codepoint_o   (head_codepoint_o),
    .not_empty_o        (not_empty_o),
    .fill_level_o       (fill_level_o),
    .dropped_o          (dropped_o)
  );

  u8cq_checker #(
    .DEPTH (DEPTH)
  ) u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .op_i               (op_i),
    .data_byte_i        (data_byte_i),
    .string_end_i       (string_end_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .popped_codepoint_i (popped_codepoint_o),
    .head_codepoint_i   (head_codepoint_o),
    .not_empty_i        (not_empty_o),
    .fill_level_i       (fill_level_o),
    .dropped_i          (dropped_o),
    .faults_o           (faults),
    .pending_o          (pending),
    .checked_o          (checked),
    .discarded_o        (discarded),
    .peak_fill_o        (peak_fill)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 2);
    else if (r < 95)
      return $urandom_range(3, 8);
    else
      return $urandom_range(20, 50);
  endfunction

  // sequence length 1 to 4, single bytes favoured
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return 1;
    else if (r < 6)
      return 2;
    else if (r < 8)
      return 3;
    else
      return 4;
  endfunction

  // continuation byte, top bits now and then wrong since they go unchecked
  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    logic [1:0] top;
    top = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b10;
    return {top, bits};
  endfunction

  // output side stalls: runs of stall and of flow, none while steady
  initial begin : rx_pacing
    int  run;
    logic hold;
    run  = 0;
    hold = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        hold = !steady && ($urandom_range(0, 2) == 0);
        run  = hold ? idle_len() : $urandom_range(1, 8);
      end
      out_stall_i <= hold;
      run--;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one input beat, with an optional gap ahead of it
  task automatic send_beat(input u8cq_pkg::op_e op, input logic [7:0] b, input logic eos);
    int gap;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    data_byte_i  <= b;
    string_end_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    if (op != u8cq_pkg::OP_NONE)
      beats_sent++;
  endtask

  // encode a random code point of the given length, leaving off cut bytes
  task automatic push_codepoint(input int len, input int cut, input logic eos_last);
    logic [20:0] v;
    logic [7:0]  seq [4];
    int          n;
    v = 21'($urandom);
    case (len)
      1: seq[0] = 8'($urandom_range(1, 127));
      2: begin
        seq[0] = {3'b110, v[10:6]};
        seq[1] = cont_byte(v[5:0]);
      end
      3: begin
        seq[0] = {4'b1110, v[15:12]};
        seq[1] = cont_byte(v[11:6]);
        seq[2] = cont_byte(v[5:0]);
      end
      default: begin
        seq[0] = {5'b11110, v[20:18]};
        seq[1] = cont_byte(v[17:12]);
        seq[2] = cont_byte(v[11:6]);
        seq[3] = cont_byte(v[5:0]);
      end
    endcase
    n = len - cut;
    for (int i = 0; i < n; i++)
      send_beat(u8cq_pkg::OP_PUSH, seq[i], eos_last && (i == n - 1));
  endtask

  // well-formed string, closed by end flag, by a zero byte or left open
  task automatic send_string();
    int n;
    int close;
    n     = $urandom_range(1, 10);
    close = $urandom_range(0, 2);
    for (int i = 0; i < n; i++)
      push_codepoint(pick_len(), 0, (close == 0) && (i == n - 1));
    if (close == 1)
      send_beat(u8cq_pkg::OP_PUSH, u8cq_pkg::NUL_BYTE, 1'($urandom));
  endtask

  // truncated sequence followed by something that breaks it
  task automatic broken_sequence();
    int len;
    len = $urandom_range(2, 4);
    push_codepoint(len, $urandom_range(1, len - 1), 1'b0);
    case ($urandom_range(0, 3))
      0: push_codepoint(pick_len(), 0, 1'b0);
      1: send_beat(u8cq_pkg::OP_PUSH, 8'($urandom), 1'b1);
      2: send_beat(u8cq_pkg::OP_PUSH, 8'($urandom_range(8'h80, 8'hBF)), 1'b0);
      default: send_beat(u8cq_pkg::OP_PUSH, 8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
    endcase
  endtask

  // long string that overflows the ring, then more of it in drop mode
  task automatic overflow_string();
    repeat ($urandom_range(DEPTH + 2, DEPTH + 10))
      send_beat(u8cq_pkg::OP_PUSH, 8'($urandom_range(1, 127)), 1'b0);
    send_beat(u8cq_pkg::OP_CONSUME, 8'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 4))
      push_codepoint(pick_len(), 0, 1'b0);
    if ($urandom_range(0, 1))
      send_beat(u8cq_pkg::OP_PUSH, u8cq_pkg::NUL_BYTE, 1'b0);
    else
      push_codepoint(1, 0, 1'b1);
    if ($urandom_range(0, 1))
      send_beat(u8cq_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int goal;
    int r;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every lead form, bad leads, zero bytes and each op
    send_beat(u8cq_pkg::OP_PUSH, 8'h41, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'h7F, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hC2, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hA9, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hE2, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'h82, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hAC, 1'b0);
    // largest 21-bit value
    send_beat(u8cq_pkg::OP_PUSH, 8'hF7, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hBF, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hBF, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hBF, 1'b0);
    // stray continuation and all-ones as lead bytes
    send_beat(u8cq_pkg::OP_PUSH, 8'h80, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'hFF, 1'b0);
    // zero continuation byte
    send_beat(u8cq_pkg::OP_PUSH, 8'hC2, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'h00, 1'b0);
    // overlong nul decodes to zero
    send_beat(u8cq_pkg::OP_PUSH, 8'hC0, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'h80, 1'b0);
    // zero lead byte ends the string
    send_beat(u8cq_pkg::OP_PUSH, u8cq_pkg::NUL_BYTE, 1'b0);
    // end flag in the middle of a sequence
    send_beat(u8cq_pkg::OP_PUSH, 8'hE2, 1'b0);
    send_beat(u8cq_pkg::OP_PUSH, 8'h82, 1'b1);
    send_beat(u8cq_pkg::OP_NONE, 8'hFF, 1'b1);
    send_beat(u8cq_pkg::OP_CONSUME, 8'h00, 1'b0);
    send_beat(u8cq_pkg::OP_CONSUME, 8'hFF, 1'b1);
    send_beat(u8cq_pkg::OP_CLEAR, 8'h5A, 1'b0);
    // consume with nothing held
    send_beat(u8cq_pkg::OP_CONSUME, 8'hA5, 1'b1);

    // random: mostly well-formed strings, plus runs of other traffic
    goal = beats_sent + RANDOM_ITEMS;
    while (beats_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_string();
      else if (r < 62)
        repeat ($urandom_range(1, 16))
          send_beat(u8cq_pkg::OP_CONSUME, 8'($urandom), 1'($urandom));
      else if (r < 75)
        broken_sequence();
      else if (r < 87)
        repeat ($urandom_range(1, 6))
          send_beat(u8cq_pkg::op_e'($urandom_range(0, 3)), 8'($urandom),
                    $urandom_range(0, 3) == 0);
      else if (r < 92)
        send_beat(u8cq_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
      else if (r < 95)
        overflow_string();
      else
        steady = !steady;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d beats driven, %0d result beats compared", beats_sent, checked);
    $display("%0d code points lost to overflow, ring peaked at %0d of %0d",
             discarded, peak_fill, DEPTH);
    if (faults == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
sv/u8cq_pkg.sv
sv/u8cq_decode.sv
sv/u8cq_ram.sv
sv/utf8_codepoint_queue.sv
sv/u8cq_checker.sv
sim/u8cq_checker.sv
sim/tb_utf8_codepoint_queue.sv
